FILE: design/slbm_pkg.sv
`timescale 1ns / 1ps

package slbm_pkg;

   // Field widths of the bus access and of the translated result.
   localparam int OpWidth     = 2;
   localparam int AddrWidth   = 16;
   localparam int DataWidth   = 8;
   localparam int MappedWidth = 18;
   localparam int TargetWidth = 2;
   localparam int MirrorWidth = 2;

   // Configuration port.
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 5;

   // Bank register widths.
   localparam int ShiftWidth   = 5;
   localparam int CountWidth   = 3;
   localparam int PrgModeWidth = 2;
   localparam int ChrBankWidth = 5;
   localparam int PrgBankWidth = 4;

   // Serial load completes on the fifth write; count value before it.
   localparam logic [CountWidth-1:0] LastSerialCount = 3'd4;

   // Largest supported program bank count.
   localparam logic [CsrDataWidth-1:0] MaxPrgBanks = 5'd16;

   typedef enum logic [OpWidth-1:0] {
      OP_PRG_WRITE = 2'd0,
      OP_PRG_READ  = 2'd1,
      OP_CHR_READ  = 2'd2,
      OP_CHR_WRITE = 2'd3
   } op_type;

   typedef enum logic [TargetWidth-1:0] {
      TGT_NONE    = 2'd0,
      TGT_PRG_ROM = 2'd1,
      TGT_CHR_ROM = 2'd2,
      TGT_CHR_RAM = 2'd3
   } target_type;

   typedef enum logic [1:0] {
      SEL_CONTROL  = 2'd0,
      SEL_CHR_LOW  = 2'd1,
      SEL_CHR_HIGH = 2'd2,
      SEL_PRG_BANK = 2'd3
   } reg_sel_type;

   typedef enum logic [PrgModeWidth-1:0] {
      PRG_MODE_32K_A     = 2'd0,
      PRG_MODE_32K_B     = 2'd1,
      PRG_MODE_FIX_FIRST = 2'd2,
      PRG_MODE_FIX_LAST  = 2'd3
   } prg_mode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CHR_RAM_PRESENT = 1'd0,
      CSR_PRG_BANK_COUNT  = 1'd1
   } csr_index_type;

   // Mapper state as seen by the translation logic.
   typedef struct packed {
      logic [ShiftWidth-1:0]   serial_shift;
      logic [CountWidth-1:0]   serial_count;
      logic                    chr_bank_mode;
      prg_mode_type            prg_bank_mode;
      logic [ChrBankWidth-1:0] chr_bank_low;
      logic [ChrBankWidth-1:0] chr_bank_high;
      logic [PrgBankWidth-1:0] prg_bank;
      logic [MirrorWidth-1:0]  mirror_mode;
      logic                    chr_ram_present;
      logic [CsrDataWidth-1:0] prg_bank_count;
   } bank_state_type;

   // Translated access, everything but the mirroring.
   typedef struct packed {
      logic [MappedWidth-1:0] mapped_address;
      target_type             target;
      logic                   ram_write;
      logic [DataWidth-1:0]   write_data;
   } xlate_result_type;

endpackage

FILE: design/slbm_req_if.sv
`timescale 1ns / 1ps

interface slbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, output operation, output address, output data, input ready);
   modport sink (input valid, input operation, input address, input data, output ready);
endinterface

FILE: design/slbm_rsp_if.sv
`timescale 1ns / 1ps

interface slbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [17:0] mapped_address;
   logic [1:0]  target;
   logic        ram_write;
   logic [7:0]  write_data;
   logic [1:0]  mirroring;

   modport source (output valid, output mapped_address, output target, output ram_write,
                   output write_data, output mirroring, input ready);
   modport sink (input valid, input mapped_address, input target, input ram_write,
                 input write_data, input mirroring, output ready);
endinterface

FILE: design/serial_load_bank_mapper.sv
`timescale 1ns / 1ps

// Channel   Direction  Carries
// req_bus   in         operation, address, data (one bus access per item)
// rsp_bus   out        mapped_address, target, ram_write, write_data, mirroring
// csr_*     in         write enable, register index, write data
//
// One item per cycle sustained while rsp_bus is ready. An item passes from the input
// register into the result register, where its result shows.
// The bank registers update as an item leaves the input register, so the next
// item sees them at once. Reset is synchronous and clears both stages.
// A stalled result holds the result register; the input register still takes
// one more item behind it.

module serial_load_bank_mapper
   import slbm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   slbm_req_if.sink                req_bus,
   slbm_rsp_if.source              rsp_bus,
   input  logic                    csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0] csr_write_data
);

   logic                   in_valid_ff;
   op_type                 in_op_ff;
   logic [AddrWidth-1:0]   in_addr_ff;
   logic [DataWidth-1:0]   in_data_ff;

   logic                   out_valid_ff;
   xlate_result_type       out_result_ff;
   logic [MirrorWidth-1:0] out_mirror_ff;

   logic                   advance;
   bank_state_type         state;
   logic [MirrorWidth-1:0] mirror_next;
   xlate_result_type       result;

   // The input register moves on when the result register is free or draining.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_op_ff   <= op_type'(req_bus.operation);
         in_addr_ff <= req_bus.address;
         in_data_ff <= req_bus.data;
      end
   end

   slbm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .op               (in_op_ff),
      .address          (in_addr_ff),
      .data             (in_data_ff),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index_type'(csr_index)),
      .csr_write_data   (csr_write_data),
      .state            (state),
      .mirror_next      (mirror_next)
   );

   slbm_xlate u_xlate (
      .op      (in_op_ff),
      .address (in_addr_ff),
      .data    (in_data_ff),
      .state   (state),
      .result  (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result;
         out_mirror_ff <= mirror_next;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.mapped_address = out_result_ff.mapped_address;
   assign rsp_bus.target         = out_result_ff.target;
   assign rsp_bus.ram_write      = out_result_ff.ram_write;
   assign rsp_bus.write_data     = out_result_ff.write_data;
   assign rsp_bus.mirroring      = out_mirror_ff;

   // The serial count never passes the fifth bit.
   assert property (@(posedge clock) disable iff (reset)
      state.serial_count <= LastSerialCount)
      else $error("serial count out of range");

   // A waiting item with a free result register shows up next cycle.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("item not moved to result register");

   // A character RAM write is only reported against character RAM.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_result_ff.ram_write |-> out_result_ff.target == TGT_CHR_RAM)
      else $error("RAM write without RAM target");

   // A serial restart write leaves fixed-last program banking behind it.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_op_ff == OP_PRG_WRITE && in_addr_ff[AddrWidth-1]
         && in_data_ff[DataWidth-1]
      |=> state.prg_bank_mode == PRG_MODE_FIX_LAST && state.serial_count == '0)
      else $error("serial restart did not take effect");

endmodule

FILE: design/slbm_ctrl.sv
`timescale 1ns / 1ps

module slbm_ctrl
   import slbm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  op_type                   op,
   input  logic [AddrWidth-1:0]     address,
   input  logic [DataWidth-1:0]     data,
   input  logic                     csr_write_enable,
   input  csr_index_type            csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data,
   output bank_state_type           state,
   output logic [MirrorWidth-1:0]   mirror_next
);

   bank_state_type state_ff, state_in;
   logic [ShiftWidth-1:0] shift_value;
   reg_sel_type           reg_sel;

   assign shift_value = {data[0], state_ff.serial_shift[ShiftWidth-1:1]};
   assign reg_sel     = reg_sel_type'(address[14:13]);

   // Serial loader and configuration registers.
   always_comb begin
      state_in = state_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CHR_RAM_PRESENT: state_in.chr_ram_present = csr_write_data[0];
            CSR_PRG_BANK_COUNT:  state_in.prg_bank_count  = csr_write_data;
            default: ;
         endcase
      end
      if (step && op == OP_PRG_WRITE && address[AddrWidth-1]) begin
         if (data[DataWidth-1]) begin
            // A write with the top data bit set restarts the serial load.
            state_in.serial_shift  = '0;
            state_in.serial_count  = '0;
            state_in.prg_bank_mode = PRG_MODE_FIX_LAST;
         end else if (state_ff.serial_count == LastSerialCount) begin
            // Fifth bit: the address picks the register that takes the value.
            state_in.serial_shift = '0;
            state_in.serial_count = '0;
            case (reg_sel)
               SEL_CONTROL: begin
                  state_in.mirror_mode   = shift_value[1:0];
                  state_in.prg_bank_mode = prg_mode_type'(shift_value[3:2]);
                  state_in.chr_bank_mode = shift_value[4];
               end
               SEL_CHR_LOW:  state_in.chr_bank_low  = shift_value;
               SEL_CHR_HIGH: state_in.chr_bank_high = shift_value;
               SEL_PRG_BANK: state_in.prg_bank      = shift_value[PrgBankWidth-1:0];
               default: ;
            endcase
         end else begin
            state_in.serial_shift = shift_value;
            state_in.serial_count = state_ff.serial_count + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.serial_shift    <= '0;
         state_ff.serial_count    <= '0;
         state_ff.chr_bank_mode   <= 1'b0;
         state_ff.prg_bank_mode   <= PRG_MODE_FIX_LAST;
         state_ff.chr_bank_low    <= '0;
         state_ff.chr_bank_high   <= '0;
         state_ff.prg_bank        <= '0;
         state_ff.mirror_mode     <= '0;
         state_ff.chr_ram_present <= 1'b0;
         state_ff.prg_bank_count  <= MaxPrgBanks;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

   // Mirroring as it stands once this item has taken effect.
   assign mirror_next = state_in.mirror_mode;

endmodule

FILE: design/slbm_xlate.sv
`timescale 1ns / 1ps

module slbm_xlate
   import slbm_pkg::*;
(
   input  op_type                 op,
   input  logic [AddrWidth-1:0]   address,
   input  logic [DataWidth-1:0]   data,
   input  bank_state_type         state,
   output xlate_result_type       result
);

   logic [PrgBankWidth-1:0] last_bank;
   logic [PrgBankWidth-1:0] prg_sel;
   logic [ChrBankWidth-1:0] chr_sel;
   logic [12:0]             chr_addr;

   assign chr_addr = address[12:0];

   // Last program bank, with the count clamped to one through sixteen.
   always_comb begin
      if (state.prg_bank_count == '0) begin
         last_bank = '0;
      end else if (state.prg_bank_count >= MaxPrgBanks) begin
         last_bank = '1;
      end else begin
         last_bank = state.prg_bank_count[PrgBankWidth-1:0] - 4'd1;
      end
   end

   // Program bank for the lower or upper 16K window.
   always_comb begin
      if (!address[14]) begin
         case (state.prg_bank_mode)
            PRG_MODE_32K_A, PRG_MODE_32K_B: prg_sel = {state.prg_bank[3:1], 1'b0};
            PRG_MODE_FIX_FIRST:             prg_sel = '0;
            default:                        prg_sel = state.prg_bank;
         endcase
      end else begin
         case (state.prg_bank_mode)
            PRG_MODE_32K_A, PRG_MODE_32K_B: prg_sel = {state.prg_bank[3:1], 1'b1};
            PRG_MODE_FIX_FIRST:             prg_sel = state.prg_bank;
            default:                        prg_sel = last_bank;
         endcase
      end
   end

   // Character bank for the lower or upper 4K window.
   always_comb begin
      if (!chr_addr[12]) begin
         chr_sel = state.chr_bank_mode ? state.chr_bank_low
                                       : {state.chr_bank_low[4:1], 1'b0};
      end else begin
         chr_sel = state.chr_bank_mode ? state.chr_bank_high
                                       : {state.chr_bank_low[4:1], 1'b1};
      end
   end

   always_comb begin
      result = '{mapped_address: '0, target: TGT_NONE, ram_write: 1'b0, write_data: '0};
      case (op)
         OP_PRG_WRITE: ;
         OP_PRG_READ: begin
            if (address[AddrWidth-1]) begin
               result.mapped_address = {prg_sel, address[13:0]};
               result.target         = TGT_PRG_ROM;
            end
         end
         OP_CHR_READ: begin
            if (state.chr_ram_present) begin
               result.mapped_address = {5'd0, chr_addr};
               result.target         = TGT_CHR_RAM;
            end else begin
               result.mapped_address = {1'b0, chr_sel, chr_addr[11:0]};
               result.target         = TGT_CHR_ROM;
            end
         end
         OP_CHR_WRITE: begin
            if (state.chr_ram_present) begin
               result.mapped_address = {5'd0, chr_addr};
               result.target         = TGT_CHR_RAM;
               result.ram_write      = 1'b1;
               result.write_data     = data;
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import slbm_pkg::*;

   localparam int PhaseCount    = 7;
   localparam int ItemsPerPhase = 205;
   localparam int WatchdogLimit = 2000;
   localparam int ReportLimit   = 40;

   localparam logic [MirrorWidth-1:0] MirrorOneScreenLow = 2'd0;
   localparam logic [MirrorWidth-1:0] MirrorHorizontal   = 2'd3;

   // One translated bus access as it leaves the block.
   typedef struct packed {
      logic [MappedWidth-1:0] mapped_address;
      target_type             target;
      logic                   ram_write;
      logic [DataWidth-1:0]   write_data;
      logic [MirrorWidth-1:0] mirroring;
   } bus_result_t;

   // One bus access, with an optional hand-written expectation.
   typedef struct packed {
      op_type               operation;
      logic [AddrWidth-1:0] address;
      logic [DataWidth-1:0] data;
      logic                 known;
      bus_result_t          want;
   } bus_access_t;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;

   slbm_req_if req_bus ();
   slbm_rsp_if rsp_bus ();

   serial_load_bank_mapper dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Mapper state and configuration as the testbench tracks them.
   logic                    chr_ram_cfg;
   logic [CsrDataWidth-1:0] prg_banks_cfg;
   logic [ShiftWidth-1:0]   shift_reg;
   logic [CountWidth-1:0]   shift_count;
   logic                    chr_4k_mode;
   prg_mode_type            prg_mode;
   logic [ChrBankWidth-1:0] chr_bank_lo;
   logic [ChrBankWidth-1:0] chr_bank_hi;
   logic [PrgBankWidth-1:0] prg_bank_sel;
   logic [MirrorWidth-1:0]  mirror_mode;

   bus_access_t queued_accesses[$];
   bus_result_t expected_translations[$];
   bus_access_t driven_access;
   int          burst_left;
   int          mismatch_count;
   int          result_count;
   int          idle_cycles;
   int          stall_style;
   int          stall_left;
   int          stall_phase;

   // Directed items. Rows marked known are checked against values typed in here; the
   // rest are checked against the translation function like the random items.
   bus_access_t directed_accesses [26] = '{
      '{OP_PRG_READ,  16'h8000, 8'h00, 1'b1, '{18'h00000, TGT_PRG_ROM, 1'b0, 8'h00,
                                               MirrorOneScreenLow}},
      '{OP_PRG_READ,  16'hFFFF, 8'h00, 1'b1, '{18'h3FFFF, TGT_PRG_ROM, 1'b0, 8'h00,
                                               MirrorOneScreenLow}},
      '{OP_PRG_READ,  16'h7FFF, 8'hFF, 1'b1, '{18'h00000, TGT_NONE, 1'b0, 8'h00,
                                               MirrorOneScreenLow}},
      '{OP_CHR_READ,  16'h0000, 8'h00, 1'b1, '{18'h00000, TGT_CHR_ROM, 1'b0, 8'h00,
                                               MirrorOneScreenLow}},
      '{OP_CHR_READ,  16'h1FFF, 8'h00, 1'b1, '{18'h01FFF, TGT_CHR_ROM, 1'b0, 8'h00,
                                               MirrorOneScreenLow}},
      '{OP_CHR_READ,  16'hFFFF, 8'hFF, 1'b1, '{18'h01FFF, TGT_CHR_ROM, 1'b0, 8'h00,
                                               MirrorOneScreenLow}},
      '{OP_CHR_WRITE, 16'h0123, 8'hAA, 1'b1, '{18'h00000, TGT_NONE, 1'b0, 8'h00,
                                               MirrorOneScreenLow}},
      '{OP_PRG_WRITE, 16'h7FFF, 8'h01, 1'b1, '{18'h00000, TGT_NONE, 1'b0, 8'h00,
                                               MirrorOneScreenLow}},
      '{OP_PRG_WRITE, 16'h8000, 8'h80, 1'b1, '{18'h00000, TGT_NONE, 1'b0, 8'h00,
                                               MirrorOneScreenLow}},
      // Control load: horizontal mirroring, 32K program mode, 4K character mode.
      '{OP_PRG_WRITE, 16'h8000, 8'h01, 1'b0, '0},
      '{OP_PRG_WRITE, 16'h9FFF, 8'h7F, 1'b0, '0},
      '{OP_PRG_WRITE, 16'h8001, 8'h00, 1'b0, '0},
      '{OP_PRG_WRITE, 16'h9000, 8'h7E, 1'b0, '0},
      '{OP_PRG_WRITE, 16'h9FFF, 8'h01, 1'b1, '{18'h00000, TGT_NONE, 1'b0, 8'h00,
                                               MirrorHorizontal}},
      '{OP_PRG_READ,  16'h8000, 8'h00, 1'b0, '0},
      '{OP_PRG_READ,  16'hC000, 8'h00, 1'b0, '0},
      '{OP_CHR_READ,  16'h1000, 8'h00, 1'b0, '0},
      // A load cut short by a reset write; mirroring must survive it.
      '{OP_PRG_WRITE, 16'hA000, 8'h01, 1'b0, '0},
      '{OP_PRG_WRITE, 16'hA000, 8'h00, 1'b0, '0},
      '{OP_PRG_WRITE, 16'hBFFF, 8'hFF, 1'b1, '{18'h00000, TGT_NONE, 1'b0, 8'h00,
                                               MirrorHorizontal}},
      // Program bank load with every bit set.
      '{OP_PRG_WRITE, 16'hE000, 8'h01, 1'b0, '0},
      '{OP_PRG_WRITE, 16'hF000, 8'h01, 1'b0, '0},
      '{OP_PRG_WRITE, 16'hFFFF, 8'h01, 1'b0, '0},
      '{OP_PRG_WRITE, 16'hE123, 8'h01, 1'b0, '0},
      '{OP_PRG_WRITE, 16'hFFFF, 8'h01, 1'b0, '0},
      '{OP_PRG_READ,  16'h8000, 8'h00, 1'b0, '0}
   };

   always #2 clock = ~clock;

   // Works out the result of one accepted bus access and advances the tracked state.
   function automatic bus_result_t translate_access(op_type op, logic [AddrWidth-1:0] addr,
                                                    logic [DataWidth-1:0] data);
      bus_result_t             res;
      logic [CsrDataWidth-1:0] eff_count;
      logic [PrgBankWidth-1:0] bank;
      logic [ChrBankWidth-1:0] chr_bank;
      res = '0;
      eff_count = (prg_banks_cfg == '0) ? 5'd1 :
                  (prg_banks_cfg > MaxPrgBanks) ? MaxPrgBanks : prg_banks_cfg;
      case (op)
         OP_PRG_WRITE: begin
            // Serial port: a set bit 7 restarts it, otherwise shift one bit in.
            if (addr[15]) begin
               if (data[7]) begin
                  shift_reg = '0;
                  shift_count = '0;
                  prg_mode = PRG_MODE_FIX_LAST;
               end else begin
                  shift_reg = {data[0], shift_reg[ShiftWidth-1:1]};
                  if (shift_count == LastSerialCount) begin
                     case (reg_sel_type'(addr[14:13]))
                        SEL_CONTROL: begin
                           mirror_mode = shift_reg[1:0];
                           prg_mode = prg_mode_type'(shift_reg[3:2]);
                           chr_4k_mode = shift_reg[4];
                        end
                        SEL_CHR_LOW:  chr_bank_lo = shift_reg;
                        SEL_CHR_HIGH: chr_bank_hi = shift_reg;
                        default:      prg_bank_sel = shift_reg[PrgBankWidth-1:0];
                     endcase
                     shift_reg = '0;
                     shift_count = '0;
                  end else begin
                     shift_count = shift_count + 1'b1;
                  end
               end
            end
         end
         OP_PRG_READ: begin
            // Bit 14 tells the upper 16K window from the lower one.
            if (addr[15]) begin
               case (prg_mode)
                  PRG_MODE_FIX_FIRST: bank = addr[14] ? prg_bank_sel : '0;
                  PRG_MODE_FIX_LAST:
                     bank = addr[14] ? PrgBankWidth'(eff_count - 5'd1) : prg_bank_sel;
                  default: bank = {prg_bank_sel[PrgBankWidth-1:1], addr[14]};
               endcase
               res.mapped_address = {bank, addr[13:0]};
               res.target = TGT_PRG_ROM;
            end
         end
         default: begin
            // Character accesses see only the low 13 address bits.
            if (chr_ram_cfg) begin
               res.mapped_address = {5'd0, addr[12:0]};
               res.target = TGT_CHR_RAM;
               if (op == OP_CHR_WRITE) begin
                  res.ram_write = 1'b1;
                  res.write_data = data;
               end
            end else if (op == OP_CHR_READ) begin
               if (!addr[12])
                  chr_bank = chr_4k_mode ? chr_bank_lo : {chr_bank_lo[ChrBankWidth-1:1], 1'b0};
               else
                  chr_bank = chr_4k_mode ? chr_bank_hi : {chr_bank_lo[ChrBankWidth-1:1], 1'b1};
               res.mapped_address = {1'b0, chr_bank, addr[11:0]};
               res.target = TGT_CHR_ROM;
            end
         end
      endcase
      res.mirroring = mirror_mode;
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
         $display("%0t ns: %s", $time, msg);
   endtask

   task automatic queue_access(op_type op, logic [AddrWidth-1:0] addr,
                               logic [DataWidth-1:0] data);
      queued_accesses.push_back('{op, addr, data, 1'b0, '0});
   endtask

   // A read or a character write, mostly inside the decoded windows.
   task automatic queue_random_access();
      op_type               op;
      logic [AddrWidth-1:0] addr;
      case ($urandom_range(0, 2))
         0:       op = OP_PRG_READ;
         1:       op = OP_CHR_READ;
         default: op = OP_CHR_WRITE;
      endcase
      if ($urandom_range(0, 7) == 0)
         addr = 16'($urandom);
      else if (op == OP_PRG_READ)
         addr = 16'($urandom_range(16'h8000, 16'hFFFF));
      else
         addr = 16'($urandom_range(0, 16'h1FFF));
      queue_access(op, addr, 8'($urandom));
   endtask

   // Mostly complete serial loads with other accesses mixed in; some cut short, some noise.
   task automatic queue_bus_episode();
      int                    kind;
      int                    n;
      logic [1:0]            sel;
      logic [ShiftWidth-1:0] value;
      kind = $urandom_range(0, 9);
      sel = 2'($urandom);
      value = 5'($urandom);
      if (kind <= 5) begin
         for (int i = 0; i < 5; i++) begin
            if ($urandom_range(0, 3) == 0)
               queue_random_access();
            if ($urandom_range(0, 11) == 0)
               queue_access(OP_PRG_WRITE, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
            queue_access(OP_PRG_WRITE,
                         {1'b1, ((i == 4) ? sel : 2'($urandom)), 13'($urandom)},
                         {1'b0, 6'($urandom), value[i]});
         end
         n = $urandom_range(0, 4);
         repeat (n) queue_random_access();
      end else if (kind == 6) begin
         n = $urandom_range(0, 4);
         repeat (n) queue_access(OP_PRG_WRITE, {1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
         queue_access(OP_PRG_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
         queue_random_access();
      end else begin
         n = $urandom_range(1, 6);
         repeat (n) queue_access(op_type'(2'($urandom)), 16'($urandom), 8'($urandom));
      end
   endtask

   // Sends the queued items in bursts with idle gaps between them. Called at a
   // falling edge and returns at one.
   task automatic drive_accesses();
      int gap;
      while (queued_accesses.size() != 0) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         driven_access = queued_accesses.pop_front();
         req_bus.valid <= 1'b1;
         req_bus.operation <= driven_access.operation;
         req_bus.address <= driven_access.address;
         req_bus.data <= driven_access.data;
         burst_left--;
         do @(posedge clock); while (!req_bus.ready);
         @(negedge clock);
      end
      req_bus.valid <= 1'b0;
   endtask

   // Waits until every item has come back and the pipeline has emptied.
   task automatic drain_results();
      while (expected_translations.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes both registers while the block is idle.
   task automatic apply_settings(logic ram_present, logic [CsrDataWidth-1:0] bank_count);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CHR_RAM_PRESENT;
      csr_write_data <= {4'($urandom), ram_present};
      @(negedge clock);
      csr_index <= CSR_PRG_BANK_COUNT;
      csr_write_data <= bank_count;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      chr_ram_cfg = ram_present;
      prg_banks_cfg = bank_count;
   endtask

   // Predict on every accepted item, check every accepted result.
   always @(posedge clock) begin : result_check
      bus_result_t predicted;
      bus_result_t want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = translate_access(op_type'(req_bus.operation), req_bus.address,
                                         req_bus.data);
            expected_translations.push_back(driven_access.known ? driven_access.want
                                                                : predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (expected_translations.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                         result_count));
            end else begin
               want = expected_translations.pop_front();
               if (rsp_bus.mapped_address !== want.mapped_address)
                  report_mismatch($sformatf("result %0d: mapped_address 0x%0h, expected 0x%0h",
                                            result_count, rsp_bus.mapped_address,
                                            want.mapped_address));
               if (rsp_bus.target !== want.target)
                  report_mismatch($sformatf("result %0d: target %0d, expected %0d",
                                            result_count, rsp_bus.target, want.target));
               if (rsp_bus.ram_write !== want.ram_write)
                  report_mismatch($sformatf("result %0d: ram_write %0d, expected %0d",
                                            result_count, rsp_bus.ram_write, want.ram_write));
               if (rsp_bus.write_data !== want.write_data)
                  report_mismatch($sformatf("result %0d: write_data 0x%0h, expected 0x%0h",
                                            result_count, rsp_bus.write_data,
                                            want.write_data));
               if (rsp_bus.mirroring !== want.mirroring)
                  report_mismatch($sformatf("result %0d: mirroring %0d, expected %0d",
                                            result_count, rsp_bus.mirroring, want.mirroring));
            end
         end
      end
   end

   // The result side stalls in styles picked at random: always ready, mostly ready, a fixed pattern, or coin flips.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= (stall_phase == 4) ? 0 : stall_phase + 1;
      case (stall_style)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_bus.ready <= (stall_phase < 3);
         default: rsp_bus.ready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   // Ends the run when nothing has moved for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
         $display("FAIL serial_load_bank_mapper");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.operation = '0;
      req_bus.address = '0;
      req_bus.data = '0;
      rsp_bus.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_CHR_RAM_PRESENT;
      csr_write_data = '0;
      driven_access = '0;
      burst_left = 0;
      mismatch_count = 0;
      result_count = 0;
      idle_cycles = 0;
      stall_style = 0;
      stall_left = 0;
      stall_phase = 0;

      // Tracked state after reset.
      chr_ram_cfg = 1'b0;
      prg_banks_cfg = MaxPrgBanks;
      shift_reg = '0;
      shift_count = '0;
      chr_4k_mode = 1'b0;
      prg_mode = PRG_MODE_FIX_LAST;
      chr_bank_lo = '0;
      chr_bank_hi = '0;
      prg_bank_sel = '0;
      mirror_mode = MirrorOneScreenLow;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_accesses[i])
         queued_accesses.push_back(directed_accesses[i]);
      drive_accesses();

      // Random phases, each under its own register setting, the extremes included.
      for (int p = 0; p < PhaseCount; p++) begin
         drain_results();
         case (p)
            0:       apply_settings(1'b0, 5'd16);
            1:       apply_settings(1'b0, 5'd1);
            2:       apply_settings(1'b1, 5'd0);
            3:       apply_settings(1'b0, 5'd31);
            4:       apply_settings(1'b1, 5'd16);
            5:       apply_settings(1'b0, 5'd17);
            default: apply_settings(1'($urandom), 5'($urandom_range(2, 15)));
         endcase
         while (queued_accesses.size() < ItemsPerPhase) queue_bus_episode();
         drive_accesses();
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS serial_load_bank_mapper");
      else
         $display("FAIL serial_load_bank_mapper");
      $finish;
   end

endmodule
